### hdl/asbd_pkg.sv
package asbd_pkg;

	localparam int WINDOW_BITS = 11;
	localparam int IDX_W       = $clog2(WINDOW_BITS);
	localparam int DATA_W      = 8;
	localparam int DCNT_W      = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 4;

	localparam logic [DCNT_W-1:0] DATA_BITS_MIN   = DCNT_W'(5);
	localparam logic [DCNT_W-1:0] DATA_BITS_MAX   = DCNT_W'(8);
	localparam logic [DCNT_W-1:0] DATA_BITS_RESET = DCNT_W'(8);

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_DATA    = 2'd0;
	localparam opcode_t OP_CARRIER = 2'd1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_DATA_BIT_COUNT = 2'd0;
	localparam cfg_idx_t CFG_STOP_BIT_COUNT = 2'd1;
	localparam cfg_idx_t CFG_LSB_FIRST      = 2'd2;

	typedef enum logic [1:0] {
		PH_WAIT_CARRIER = 2'd0,
		PH_WAIT_MARK    = 2'd1,
		PH_ARMED        = 2'd2
	} phase_t;

	typedef struct packed {
		logic value;
		logic valid;
	} cell_link_t;

	typedef struct packed {
		logic append;
		logic shift;
		logic clear;
		logic line_bit;
	} cell_ctl_t;

endpackage

### hdl/asbd_in_if.sv
interface asbd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic       line_bit;

	modport source (output valid, output opcode, output line_bit, input ready);
	modport sink (input valid, input opcode, input line_bit, output ready);
endinterface

### hdl/asbd_out_if.sv
interface asbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

### hdl/asbd_cell.sv
module asbd_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  asbd_pkg::cell_ctl_t    ctl,
	input  logic                   lower_valid,
	input  asbd_pkg::cell_link_t   upper_post,
	output asbd_pkg::cell_link_t   post,
	output asbd_pkg::cell_link_t   held
);
	import asbd_pkg::*;

	logic value_q;
	logic valid_q;
	logic insert;

	// The incoming bit lands in the lowest empty cell.
	assign insert     = ctl.append && !valid_q && lower_valid;
	assign post.value = insert ? ctl.line_bit : value_q;
	assign post.valid = valid_q || insert;
	assign held.value = value_q;
	assign held.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= upper_post.valid;
		end else if (ctl.append) begin
			valid_q <= post.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= upper_post.value;
		end else if (ctl.append) begin
			value_q <= post.value;
		end
	end
endmodule

### hdl/asbd_frame_chk.sv
module asbd_frame_chk (
	input  logic [asbd_pkg::WINDOW_BITS-1:0] win_value,
	input  logic [asbd_pkg::WINDOW_BITS-1:0] win_valid,
	input  logic [asbd_pkg::DCNT_W-1:0]      data_bits,
	input  logic                             two_stop,
	input  logic                             lsb_first,
	output logic                             full,
	output logic                             good,
	output logic [asbd_pkg::DATA_W-1:0]      ch
);
	import asbd_pkg::*;

	logic [IDX_W-1:0] last_idx;
	logic [IDX_W-1:0] stop1_idx;
	logic [IDX_W-1:0] stop2_idx;

	assign last_idx  = IDX_W'(data_bits) + IDX_W'(1) + IDX_W'(two_stop);
	assign stop1_idx = IDX_W'(data_bits) + IDX_W'(1);
	assign stop2_idx = IDX_W'(data_bits) + IDX_W'(2);

	assign full = win_valid[last_idx];
	assign good = !win_value[0] && win_value[stop1_idx] && (!two_stop || win_value[stop2_idx]);

	always_comb begin
		ch = '0;
		for (int i = 0; i < DATA_W; i++) begin
			if (DCNT_W'(i) < data_bits) begin
				if (lsb_first) begin
					ch[i] = win_value[IDX_W'(i + 1)];
				end else begin
					ch[i] = win_value[IDX_W'(data_bits) - IDX_W'(i)];
				end
			end
		end
	end
endmodule

### hdl/async_serial_bit_deframer.sv
// A character is shown on dout in the cycle after the transfer of its last stop bit.
// Throughput: one line event per cycle while din is ready; every window cell updates in the cycle of the transfer.
// The output register holds one character, so din stalls only while a character waits and dout is not ready.
// Reset: 8 data bits, 1 stop bit, MSB first, window empty, waiting for carrier.
// The window cells reset their valid flags at once; no clearing pass is needed.
module async_serial_bit_deframer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [asbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [asbd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	asbd_in_if.sink                             din,
	asbd_out_if.source                          dout
);
	import asbd_pkg::*;

	logic [DCNT_W-1:0]      data_bits_q;
	logic                   two_stop_q;
	logic                   lsb_first_q;
	phase_t                 phase_q;
	phase_t                 phase_d;
	logic                   out_valid_q;
	logic [DATA_W-1:0]      data_byte_q;

	logic                   accept;
	logic                   data_en;
	logic                   cfg_clear;
	logic                   full;
	logic                   good;
	logic [DATA_W-1:0]      ch;
	cell_ctl_t              ctl;
	cell_link_t             post [WINDOW_BITS];
	cell_link_t             held [WINDOW_BITS];
	logic [WINDOW_BITS-1:0] post_value;
	logic [WINDOW_BITS-1:0] post_valid;
	logic [WINDOW_BITS-1:0] held_valid;

	assign din.ready      = !out_valid_q || dout.ready;
	assign accept         = din.valid && din.ready;
	assign dout.valid     = out_valid_q;
	assign dout.data_byte = data_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q <= DATA_BITS_RESET;
			two_stop_q  <= 1'b0;
			lsb_first_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DATA_BIT_COUNT: begin
					if (cfg_wdata < DATA_BITS_MIN) begin
						data_bits_q <= DATA_BITS_MIN;
					end else if (cfg_wdata > DATA_BITS_MAX) begin
						data_bits_q <= DATA_BITS_MAX;
					end else begin
						data_bits_q <= cfg_wdata;
					end
				end
				CFG_STOP_BIT_COUNT: two_stop_q <= cfg_wdata[1];
				CFG_LSB_FIRST: lsb_first_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg_clear = cfg_we &&
		(cfg_index == CFG_DATA_BIT_COUNT || cfg_index == CFG_STOP_BIT_COUNT);

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			unique case (phase_q)
				PH_ARMED: phase_d = PH_ARMED;
				PH_WAIT_MARK: begin
					if (din.opcode == OP_DATA && din.line_bit) begin
						phase_d = PH_ARMED;
					end
				end
				default: begin
					if (din.opcode == OP_CARRIER) begin
						phase_d = PH_WAIT_MARK;
					end else begin
						phase_d = PH_WAIT_CARRIER;
					end
				end
			endcase
		end
	end

	always_comb begin
		data_en = accept && phase_q == PH_ARMED && din.opcode == OP_DATA;
		ctl.append   = data_en;
		ctl.line_bit = din.line_bit;
		ctl.shift    = data_en && full && !good;
		ctl.clear    = cfg_clear || (data_en && full && good);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_CARRIER;
		end else begin
			phase_q <= phase_d;
		end
	end

	for (genvar i = 0; i < WINDOW_BITS; i++) begin : g_cell
		logic       lower_valid;
		cell_link_t upper_post;

		if (i == 0) begin : g_first
			assign lower_valid = 1'b1;
		end else begin : g_inner
			assign lower_valid = held[i-1].valid;
		end

		if (i == WINDOW_BITS - 1) begin : g_last
			assign upper_post = '0;
		end else begin : g_below
			assign upper_post = post[i+1];
		end

		asbd_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.lower_valid (lower_valid),
			.upper_post  (upper_post),
			.post        (post[i]),
			.held        (held[i])
		);

		assign post_value[i] = post[i].value;
		assign post_valid[i] = post[i].valid;
		assign held_valid[i] = held[i].valid;
	end

	asbd_frame_chk u_frame_chk (
		.win_value (post_value),
		.win_valid (post_valid),
		.data_bits (data_bits_q),
		.two_stop  (two_stop_q),
		.lsb_first (lsb_first_q),
		.full      (full),
		.good      (good),
		.ch        (ch)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (data_en && full && good) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_en && full && good) begin
			data_byte_q <= ch;
		end
	end

	// The filled cells always form a contiguous run from the oldest bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		((held_valid + WINDOW_BITS'(1)) & held_valid) == '0)
		else $error("window cells are not filled from the bottom");

	// A frame is checked as its last bit enters the window, so the topmost cell never holds a bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		!held_valid[WINDOW_BITS-1])
		else $error("window overflow");

	// A good frame empties the whole window.
	assert property (@(posedge clk) disable iff (!arst_n)
		(data_en && full && good) |=> held_valid == '0)
		else $error("window not cleared after a good frame");

	// Once armed, the receiver stays armed.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ARMED |=> phase_q == PH_ARMED)
		else $error("receiver left the armed phase");
endmodule

### test/tb_async_serial_bit_deframer.sv
module tb_async_serial_bit_deframer;
	import asbd_pkg::*;

	localparam opcode_t  OP_STATUS    = 2'd2;
	localparam opcode_t  OP_SPARE     = 2'd3;
	localparam cfg_idx_t CFG_SPARE    = 2'd3;
	localparam int       STALL_LIMIT  = 3000;
	localparam int       PHASES       = 12;
	localparam int       PHASE_EVENTS = 100;
	localparam int       MAX_REPORTS  = 100;
	localparam int       SETTLE       = 4;
	localparam int       PLAN_ROWS    = 32;

	typedef enum logic {
		ROW_EVENT,
		ROW_WRITE
	} row_kind_t;

	typedef enum logic [1:0] {
		EXP_MODEL,
		EXP_NONE,
		EXP_BYTE
	} row_exp_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  code;
		logic [3:0]  value;
		row_exp_t    exp_kind;
		logic [7:0]  exp_byte;
	} plan_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	asbd_in_if  line_ch ();
	asbd_out_if char_ch ();

	async_serial_bit_deframer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.din       (line_ch),
		.dout      (char_ch)
	);

	// Shadow of the deframer state and its register settings.
	logic [WINDOW_BITS-1:0] rx_window;
	int                     rx_fill;
	phase_t                 rx_phase;
	logic [3:0]             set_data_bits;
	logic [1:0]             set_stop_bits;
	logic                   set_lsb_first;

	logic [7:0] pending_chars [$];

	int mismatches;
	int data_events;
	int chars_checked;
	int reg_writes;
	int broken_frames;
	int src_idle_pct;
	int dst_idle_pct;

	plan_row_t opening_plan [PLAN_ROWS] = '{
		'{ROW_EVENT, OP_DATA,    4'd1, EXP_NONE,  8'h00},
		'{ROW_EVENT, OP_STATUS,  4'd0, EXP_NONE,  8'h00},
		'{ROW_EVENT, OP_CARRIER, 4'd0, EXP_NONE,  8'h00},
		'{ROW_EVENT, OP_CARRIER, 4'd1, EXP_NONE,  8'h00},
		'{ROW_EVENT, OP_DATA,    4'd0, EXP_NONE,  8'h00},
		'{ROW_EVENT, OP_SPARE,   4'd1, EXP_NONE,  8'h00},
		'{ROW_EVENT, OP_DATA,    4'd1, EXP_NONE,  8'h00},
		'{ROW_EVENT, OP_CARRIER, 4'd0, EXP_NONE,  8'h00},
		'{ROW_EVENT, OP_DATA,    4'd0, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd1, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd0, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd1, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd0, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd0, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd1, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd0, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd1, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd1, EXP_BYTE,  8'hA5},
		'{ROW_EVENT, OP_DATA,    4'd0, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd1, EXP_MODEL, 8'h00},
		'{ROW_WRITE, CFG_DATA_BIT_COUNT, 4'd0, EXP_NONE, 8'h00},
		'{ROW_WRITE, CFG_STOP_BIT_COUNT, 4'd3, EXP_NONE, 8'h00},
		'{ROW_WRITE, CFG_LSB_FIRST,      4'd1, EXP_NONE, 8'h00},
		'{ROW_WRITE, CFG_SPARE,          4'hF, EXP_NONE, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd0, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd1, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd0, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd1, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd1, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd0, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd1, EXP_MODEL, 8'h00},
		'{ROW_EVENT, OP_DATA,    4'd1, EXP_BYTE,  8'h0D}
	};

	function automatic int frame_data_bits();
		if (set_data_bits < DATA_BITS_MIN) return int'(DATA_BITS_MIN);
		if (set_data_bits > DATA_BITS_MAX) return int'(DATA_BITS_MAX);
		return int'(set_data_bits);
	endfunction

	function automatic int frame_stop_bits();
		if (set_stop_bits == 2'd0) return 1;
		if (set_stop_bits == 2'd3) return 2;
		return int'(set_stop_bits);
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
	endtask

	task automatic apply_register(input cfg_idx_t idx, input logic [3:0] value);
		case (idx)
			CFG_DATA_BIT_COUNT: begin
				set_data_bits = value;
				rx_window     = '0;
				rx_fill       = 0;
			end
			CFG_STOP_BIT_COUNT: begin
				set_stop_bits = value[1:0];
				rx_window     = '0;
				rx_fill       = 0;
			end
			CFG_LSB_FIRST: begin
				set_lsb_first = value[0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic deframe_event(input opcode_t op, input logic b,
			output logic got_char, output logic [7:0] char_out);
		int   d;
		int   s;
		logic good;
		got_char = 1'b0;
		char_out = '0;
		if (rx_phase != PH_ARMED) begin
			if (op == OP_CARRIER) begin
				rx_phase = PH_WAIT_MARK;
			end else if (op == OP_DATA && b && rx_phase == PH_WAIT_MARK) begin
				rx_phase = PH_ARMED;
			end else if (rx_phase != PH_WAIT_MARK) begin
				rx_phase = PH_WAIT_CARRIER;
			end
			return;
		end
		if (op != OP_DATA) return;
		d = frame_data_bits();
		s = frame_stop_bits();
		if (rx_fill >= WINDOW_BITS) begin
			rx_window = rx_window >> 1;
			rx_fill   = WINDOW_BITS - 1;
		end
		rx_window[rx_fill] = b;
		rx_fill++;
		if (rx_fill < 1 + d + s) return;
		good = !rx_window[0] && rx_window[1 + d] && (s == 1 || rx_window[2 + d]);
		if (!good) begin
			rx_window = rx_window >> 1;
			rx_fill--;
			return;
		end
		for (int i = 0; i < d; i++) begin
			char_out[i] = set_lsb_first ? rx_window[1 + i] : rx_window[d - i];
		end
		got_char  = 1'b1;
		rx_window = '0;
		rx_fill   = 0;
	endtask

	// One line event: random gap, transfer, then the expectation it causes.
	task automatic send_event(input opcode_t op, input logic b,
			input row_exp_t exp_kind, input logic [7:0] typed_char);
		logic       got_char;
		logic [7:0] char_out;
		while ($urandom_range(99) < src_idle_pct) begin
			line_ch.valid <= 1'b0;
			@(posedge clk);
		end
		line_ch.valid    <= 1'b1;
		line_ch.opcode   <= op;
		line_ch.line_bit <= b;
		@(posedge clk);
		while (!line_ch.ready) @(posedge clk);
		deframe_event(op, b, got_char, char_out);
		if (op == OP_DATA) data_events++;
		case (exp_kind)
			EXP_MODEL: if (got_char) pending_chars.push_back(char_out);
			EXP_BYTE:  pending_chars.push_back(typed_char);
			default: begin
			end
		endcase
	endtask

	task automatic settle(input int cycles);
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [3:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		apply_register(idx, value);
		reg_writes++;
	endtask

	task automatic configure_phase(input int phase);
		logic [3:0] dbits;
		logic [3:0] sbits;
		logic [3:0] lsb;
		case (phase % 4)
			0: begin
				dbits = 4'd5;
				sbits = 4'd1;
				lsb   = 4'd0;
			end
			1: begin
				dbits = 4'd8;
				sbits = 4'd2;
				lsb   = 4'd1;
			end
			2: begin
				dbits = 4'd15;
				sbits = 4'd0;
				lsb   = 4'd0;
			end
			default: begin
				dbits = 4'($urandom_range(15));
				sbits = 4'($urandom_range(15));
				lsb   = 4'($urandom_range(15));
			end
		endcase
		line_ch.valid <= 1'b0;
		settle(SETTLE);
		write_register(CFG_LSB_FIRST, lsb);
		write_register(CFG_DATA_BIT_COUNT, dbits);
		write_register(CFG_STOP_BIT_COUNT, sbits);
		if ($urandom_range(1)) write_register(CFG_SPARE, 4'($urandom_range(15)));
		cfg_we <= 1'b0;
	endtask

	task automatic send_frame(input logic broken);
		logic [15:0] bits;
		int          d;
		int          s;
		int          len;
		int          pos;
		d    = frame_data_bits();
		s    = frame_stop_bits();
		len  = 1 + d + s;
		bits = '0;
		for (int i = 1; i <= d; i++) bits[i] = 1'($urandom_range(1));
		for (int i = d + 1; i < len; i++) bits[i] = 1'b1;
		if (broken) begin
			broken_frames++;
			if ($urandom_range(1)) begin
				pos       = $urandom_range(s);
				pos       = (pos == 0) ? 0 : d + pos;
				bits[pos] = ~bits[pos];
			end else begin
				len = $urandom_range(len - 1, 1);
			end
		end
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(19) == 0) begin
				send_event(opcode_t'($urandom_range(3, 1)), 1'($urandom_range(1)),
					EXP_MODEL, 8'h00);
			end
			send_event(OP_DATA, bits[i], EXP_MODEL, 8'h00);
		end
	endtask

	task automatic run_traffic(input int count);
		int first;
		int pick;
		first = data_events;
		while (data_events - first < count) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_frame(1'b0);
			end else if (pick < 85) begin
				send_frame(1'b1);
			end else if (pick < 95) begin
				send_event(OP_DATA, 1'($urandom_range(1)), EXP_MODEL, 8'h00);
			end else begin
				send_event(opcode_t'($urandom_range(3, 1)), 1'($urandom_range(1)),
					EXP_MODEL, 8'h00);
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		char_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			char_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && char_ch.valid && char_ch.ready) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("character %02h with none expected",
					char_ch.data_byte));
			end else begin
				if (char_ch.data_byte !== pending_chars[0]) begin
					report_mismatch($sformatf("data_byte %02h, expected %02h",
						char_ch.data_byte, pending_chars[0]));
				end
				void'(pending_chars.pop_front());
				chars_checked++;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((line_ch.valid && line_ch.ready) || (char_ch.valid && char_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("no transfer for %0d cycles, %0d characters outstanding",
			STALL_LIMIT, pending_chars.size());
		$display("async_serial_bit_deframer test failed");
		$finish;
	end

	initial begin
		logic writing;
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_DATA_BIT_COUNT;
		cfg_wdata        <= '0;
		line_ch.valid    <= 1'b0;
		line_ch.opcode   <= OP_DATA;
		line_ch.line_bit <= 1'b0;
		mismatches    = 0;
		data_events   = 0;
		chars_checked = 0;
		reg_writes    = 0;
		broken_frames = 0;
		src_idle_pct  = 6;
		dst_idle_pct  = 73;
		set_data_bits = DATA_BITS_RESET;
		set_stop_bits = 2'd1;
		set_lsb_first = 1'b0;
		rx_window     = '0;
		rx_fill       = 0;
		rx_phase      = PH_WAIT_CARRIER;
		writing       = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_plan[i]) begin
			if (opening_plan[i].kind == ROW_WRITE) begin
				if (!writing) begin
					line_ch.valid <= 1'b0;
					settle(SETTLE);
					writing = 1'b1;
				end
				write_register(cfg_idx_t'(opening_plan[i].code), opening_plan[i].value);
			end else begin
				if (writing) begin
					cfg_we  <= 1'b0;
					writing = 1'b0;
				end
				send_event(opcode_t'(opening_plan[i].code), opening_plan[i].value[0],
					opening_plan[i].exp_kind, opening_plan[i].exp_byte);
			end
		end

		// Sender mostly busy and receiver mostly stalled, then the reverse, then flat out.
		for (int p = 0; p < PHASES; p++) begin
			case (p / 4)
				0: begin
					src_idle_pct = 6;
					dst_idle_pct = 73;
				end
				1: begin
					src_idle_pct = 73;
					dst_idle_pct = 6;
				end
				default: begin
					src_idle_pct = 0;
					dst_idle_pct = 0;
				end
			endcase
			configure_phase(p);
			run_traffic(PHASE_EVENTS);
		end

		line_ch.valid <= 1'b0;
		settle(10);
		$display("%0d data bit transfers over %0d register writes, %0d broken frames sent",
			data_events, reg_writes, broken_frames);
		$display("%0d characters checked, %0d mismatches", chars_checked, mismatches);
		if (mismatches == 0) begin
			$display("async_serial_bit_deframer test passed");
		end else begin
			$display("async_serial_bit_deframer test failed");
		end
		$finish;
	end

endmodule
